[rtl/fcdp_pkg.sv]
// ----------------------------------------------------------------------------
// fcdp_pkg: shared types for the float constant dedup pool
// Request/response structs, status codes, ctrl/datapath bundles, narrowing.
// ----------------------------------------------------------------------------
package fcdp_pkg;

   localparam int unsigned PoolDepthDefault = 64;

   typedef enum logic [1:0] {
      TYPE_SINGLE = 2'd0,
      TYPE_DOUBLE = 2'd1
   } type_code_type;

   typedef enum logic [1:0] {
      STATUS_REUSED  = 2'd0,
      STATUS_ADDED   = 2'd1,
      STATUS_NOPOOL  = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic        is_constant;
      logic [1:0]  type_code;
      logic [63:0] value_bits;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] pool_id;
      logic       in_double_pool;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, clear scan index
      logic step;      // advance scan index
      logic append;    // write key at count, bump count
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic poolable;
      logic scan_done; // index reached count (no more entries)
      logic hit;       // current entry matches
      logic full;
   } sts_type;

   // double to single, round to nearest even
   // mantissa path is 54 bits so the half point at shift 54 is representable
   function automatic logic [31:0] narrow_to_single(input logic [63:0] b);
      logic        sgn;
      logic [10:0] dexp;
      logic [51:0] man;
      logic [53:0] m;
      logic [12:0] fe;       // signed biased single exponent
      logic [6:0]  shift;
      logic [53:0] q;
      logic [53:0] rem;
      logic [53:0] half;
      logic [53:0] mask;
      logic [31:0] mag;
      logic [31:0] res;
      sgn  = b[63];
      dexp = b[62:52];
      man  = b[51:0];
      m    = {2'b01, man};
      fe   = 13'(dexp) - 13'd896;
      res  = {sgn, 31'd0};
      if (dexp == 11'h7FF) begin
         if (man == 52'd0) res = {sgn, 31'h7F800000};
         else res = {sgn, 31'h7FC00000 | 31'(man[51:29])};
      end else if (dexp == 11'd0) begin
         res = {sgn, 31'd0};
      end else if (!fe[12] && fe >= 13'd255) begin
         res = {sgn, 31'h7F800000};
      end else begin
         if (!fe[12] && fe != 13'd0) shift = 7'd29;
         else shift = 7'(13'd30 - fe);
         if (fe[12] && (13'd0 - fe) > 13'd24) begin
            res = {sgn, 31'd0};
         end else begin
            mask = (54'd1 << shift) - 54'd1;
            q    = m >> shift;
            rem  = m & mask;
            half = 54'd1 << (shift - 7'd1);
            if (rem > half || (rem == half && q[0])) q = q + 54'd1;
            if (!fe[12] && fe != 13'd0)
               mag = ({19'd0, fe - 13'd1} << 23) + q[31:0];
            else
               mag = q[31:0];
            if (mag >= 32'h7F800000) mag = 32'h7F800000;
            res = {sgn, mag[30:0]};
         end
      end
      return res;
   endfunction

endpackage

[rtl/fcdp_ctrl.sv]
// ----------------------------------------------------------------------------
// fcdp_ctrl: request sequencing for the constant pool
// Loads a request, scans one entry per cycle, appends or reports, holds rsp.
// ----------------------------------------------------------------------------
module fcdp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fcdp_pkg::cmd_type cmd,
   input  fcdp_pkg::sts_type sts,
   output logic [1:0]        rsp_code
);
   import fcdp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [1:0] code_ff, code_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_code  = code_ff;

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      code_in    = code_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!sts.poolable) begin
               code_in  = STATUS_NOPOOL;
               valid_in = 1'b1;
               state_in = ST_RESP;
            end else if (sts.scan_done) begin
               if (sts.full) begin
                  code_in = STATUS_FULL;
               end else begin
                  code_in    = STATUS_ADDED;
                  cmd.append = 1'b1;
               end
               valid_in = 1'b1;
               state_in = ST_RESP;
            end else if (sts.hit) begin
               code_in  = STATUS_REUSED;
               valid_in = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         code_ff  <= STATUS_NOPOOL;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         code_ff  <= code_in;
      end
   end

endmodule

[rtl/fcdp_dpath.sv]
// ----------------------------------------------------------------------------
// fcdp_dpath: pool memories, counts, scan index and compare
// One entry read per cycle from each pool; key narrowed at load.
// ----------------------------------------------------------------------------
module fcdp_dpath #(
   parameter int unsigned POOL_DEPTH = fcdp_pkg::PoolDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  fcdp_pkg::req_type req_data,
   input  fcdp_pkg::cmd_type cmd,
   output fcdp_pkg::sts_type sts,
   output logic [5:0]        rsp_id,
   output logic              rsp_dbl
);
   import fcdp_pkg::*;

   localparam int unsigned AW = $clog2(POOL_DEPTH);
   localparam int unsigned CW = AW + 1;

   logic [31:0] single_mem [POOL_DEPTH];
   logic [63:0] double_mem [POOL_DEPTH];

   logic [CW-1:0] scount_ff, dcount_ff;
   logic [CW-1:0] idx_ff;
   logic          dbl_ff, pool_ff;
   logic [63:0]   key_ff;
   logic [31:0]   srd_ff;
   logic [63:0]   drd_ff;
   logic          rd_ok_ff;
   logic [CW-1:0] count;
   logic [AW-1:0] rd_addr;
   logic          hit;
   logic [62:0]   ka, ea;
   logic [30:0]   ks, es;

   assign count   = dbl_ff ? dcount_ff : scount_ff;
   assign rd_addr = cmd.load ? '0 : idx_ff[AW-1:0] + AW'(cmd.step);

   // read data registered; compare on entry at idx_ff
   always_ff @(posedge clock) begin
      srd_ff <= single_mem[rd_addr];
      drd_ff <= double_mem[rd_addr];
      if (cmd.append && !dbl_ff) single_mem[scount_ff[AW-1:0]] <= key_ff[31:0];
      if (cmd.append && dbl_ff)  double_mem[dcount_ff[AW-1:0]] <= key_ff;
   end

   always_comb begin
      ka = key_ff[62:0];
      ea = drd_ff[62:0];
      ks = key_ff[30:0];
      es = srd_ff[30:0];
      if (dbl_ff)
         hit = !(ka > 63'h7FF0000000000000) && !(ea > 63'h7FF0000000000000)
               && (key_ff == drd_ff || (ka == '0 && ea == '0));
      else
         hit = !(ks > 31'h7F800000) && !(es > 31'h7F800000)
               && (key_ff[31:0] == srd_ff || (ks == '0 && es == '0));
   end

   assign sts.poolable  = pool_ff;
   assign sts.scan_done = (idx_ff >= count);
   assign sts.hit       = hit && rd_ok_ff;
   assign sts.full      = (count >= CW'(POOL_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         scount_ff <= '0;
         dcount_ff <= '0;
         rd_ok_ff  <= 1'b0;
      end else begin
         rd_ok_ff <= cmd.load || cmd.step;
         if (cmd.append && !dbl_ff) scount_ff <= scount_ff + CW'(1);
         if (cmd.append && dbl_ff)  dcount_ff <= dcount_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff  <= '0;
         dbl_ff  <= (req_data.type_code == TYPE_DOUBLE);
         pool_ff <= req_data.is_constant && (req_data.type_code == TYPE_SINGLE
                    || req_data.type_code == TYPE_DOUBLE);
         key_ff  <= (req_data.type_code == TYPE_DOUBLE) ? req_data.value_bits
                    : {32'd0, narrow_to_single(req_data.value_bits)};
      end else if (cmd.step) begin
         idx_ff <= idx_ff + CW'(1);
      end
   end

   // id: scan index, which is the entry on a hit and the count on append
   assign rsp_id  = 6'(idx_ff);
   assign rsp_dbl = dbl_ff && pool_ff;

endmodule

[rtl/float_constant_dedup_pool.sv]
// ----------------------------------------------------------------------------
// float_constant_dedup_pool: deduplicating pool of f32/f64 constants
// Scan: stops at the first matching entry on a hit and runs over all count
// entries on a miss; one pool entry compared per cycle.
// Throughput: one request in flight; the next is taken once the response has
// been accepted and the controller is back in idle.
// Reset (synchronous) empties both pools; no clearing pass is needed.
// ----------------------------------------------------------------------------
module float_constant_dedup_pool #(
   parameter int unsigned POOL_DEPTH = fcdp_pkg::PoolDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fcdp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fcdp_pkg::rsp_type rsp_data
);
   import fcdp_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [1:0] code;
   logic [5:0] id_raw;
   logic       dbl;
   logic [5:0] id_ff;
   logic       dbl_ff;

   fcdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_code  (code)
   );

   fcdp_dpath #(.POOL_DEPTH(POOL_DEPTH)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_id   (id_raw),
      .rsp_dbl  (dbl)
   );

   // response id captured on a hit or an append as the scan ends, else zero;
   // pool flag registered each cycle; the end of the scan takes priority over a compare, as in the controller
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff <= '0;
      end else if (sts.poolable && (sts.scan_done ? !sts.full : sts.hit)
                   && !rsp_valid) begin
         id_ff <= id_raw;
      end
      dbl_ff <= dbl;
   end

   assign rsp_data.status         = code;
   assign rsp_data.pool_id        = id_ff;
   assign rsp_data.in_double_pool = dbl_ff;

endmodule

[verif/tb_float_constant_dedup_pool.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_float_constant_dedup_pool: self-checking bench for the constant pool
// Drives f32/f64 constant requests, predicts status and index with its own
// pool model (double-to-single narrowing, IEEE equality), checks responses.
// ----------------------------------------------------------------------------
module tb_float_constant_dedup_pool;
   import fcdp_pkg::*;

   localparam int unsigned Depth = PoolDepthDefault;

   // pool model plus queue of expected responses
   class pool_scoreboard;
      logic [31:0] single_vals[Depth];
      logic [63:0] double_vals[Depth];
      int unsigned single_used;
      int unsigned double_used;
      rsp_type     pending[$];
      int unsigned errors;

      function new();
         single_used = 0;
         double_used = 0;
         errors      = 0;
      endfunction

      // double to single, round to nearest even, on bit patterns
      function logic [31:0] to_single(logic [63:0] b);
         logic [31:0] sgn;
         int          dexp;
         logic [63:0] mant;
         logic [63:0] q;
         logic [63:0] rem;
         logic [63:0] half;
         int          fe;
         int          sh;
         logic [31:0] mag;
         sgn  = {b[63], 31'd0};
         dexp = int'(b[62:52]);
         mant = {12'd0, b[51:0]};
         if (dexp == 2047) begin
            if (mant == 0) return sgn | 32'h7F800000;
            return sgn | 32'h7FC00000 | 32'(mant >> 29);
         end
         if (dexp == 0) return sgn;
         mant = mant | (64'd1 << 52);
         fe   = dexp - 1023 + 127;
         if (fe >= 255) return sgn | 32'h7F800000;
         sh = (fe >= 1) ? 29 : 30 - fe;
         if (sh > 54) return sgn;
         q    = mant >> sh;
         rem  = mant & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 1;
         if (fe >= 1) mag = (32'(fe - 1) << 23) + q[31:0];
         else mag = q[31:0];
         if (mag >= 32'h7F800000) mag = 32'h7F800000;
         return sgn | mag;
      endfunction

      function bit same_single(logic [31:0] a, logic [31:0] b);
         if (a[30:0] > 31'h7F800000 || b[30:0] > 31'h7F800000) return 0;
         return a == b || (a[30:0] == 0 && b[30:0] == 0);
      endfunction

      function bit same_double(logic [63:0] a, logic [63:0] b);
         if (a[62:0] > 63'h7FF0000000000000 || b[62:0] > 63'h7FF0000000000000) return 0;
         return a == b || (a[62:0] == 0 && b[62:0] == 0);
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         logic [31:0] s;
         e = '{status: STATUS_NOPOOL, pool_id: 0, in_double_pool: 0};
         if (r.is_constant && r.type_code == TYPE_SINGLE) begin
            s = to_single(r.value_bits);
            e.status = STATUS_FULL;
            for (int i = 0; i < single_used; i++)
               if (same_single(single_vals[i], s)) begin
                  e.status  = STATUS_REUSED;
                  e.pool_id = 6'(i);
                  break;
               end
            if (e.status == STATUS_FULL && single_used < Depth) begin
               single_vals[single_used] = s;
               e.status  = STATUS_ADDED;
               e.pool_id = 6'(single_used);
               single_used++;
            end
         end else if (r.is_constant && r.type_code == TYPE_DOUBLE) begin
            e.in_double_pool = 1;
            e.status = STATUS_FULL;
            for (int i = 0; i < double_used; i++)
               if (same_double(double_vals[i], r.value_bits)) begin
                  e.status  = STATUS_REUSED;
                  e.pool_id = 6'(i);
                  break;
               end
            if (e.status == STATUS_FULL && double_used < Depth) begin
               double_vals[double_used] = r.value_bits;
               e.status  = STATUS_ADDED;
               e.pool_id = 6'(double_used);
               double_used++;
            end
         end
         pending = {pending, e};
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
         end
         if (a.pool_id !== e.pool_id) begin
            $error("pool_id: expected %0d, got %0d", e.pool_id, a.pool_id);
            errors++;
         end
         if (a.in_double_pool !== e.in_double_pool) begin
            $error("in_double_pool: expected %0d, got %0d", e.in_double_pool,
                   a.in_double_pool);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1;
   rsp_type rsp_data;

   pool_scoreboard board = new();
   bit      long_hold = 0;    // receiver holds off while this is set

   always #10 clock = ~clock;

   float_constant_dedup_pool i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // offer one request after a random gap; returns once it is taken
   // valid stays up across a zero gap so the next request follows directly
   task automatic send_request(req_type r);
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;   // runs without gaps
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
   endtask

   task automatic send_op(bit c, logic [1:0] t, logic [63:0] v);
      req_type r;
      r.is_constant = c;
      r.type_code   = t;
      r.value_bits  = v;
      send_request(r);
   endtask

   // draws a value: random bits, pool-reuse candidates, or float specials
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0, 1: v = {1'($urandom_range(0, 1)), 11'h3FF, 49'd0,
                    3'($urandom_range(0, 7))};
         2: v = {v[63], 11'h7FF, v[51:0]};                    // inf / NaN
         3: v = {v[63], 11'($urandom_range(860, 1200)), v[51:0]}; // narrowing edges
         4: v = {v[63], 63'd0};                               // signed zeros
         default: ;
      endcase
      return v;
   endfunction

   // receiver: random stall per response, plus the long hold-off
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = $urandom_range(0, 12);
         if ($urandom_range(0, 3) == 0) wait_cycles = 0;
         if (wait_cycles != 0 || long_hold) begin
            rsp_stall <= 1;
            repeat (wait_cycles) @(posedge clock);
            while (long_hold) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
         board.check_response(rsp_data);
      end
   end

   // long hold-off, counted here while the sender keeps offering
   initial begin
      @(negedge reset);
      repeat (3000) @(posedge clock);
      long_hold = 1;
      repeat (400) @(posedge clock);
      long_hold = 0;
   end

   initial begin
      logic [1:0] t;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: not poolable, zeros, NaN, infinities, narrowing corners
      send_op(0, TYPE_SINGLE, 64'h3FF0000000000000);
      send_op(1, 2'd2, 64'hFFFFFFFFFFFFFFFF);
      send_op(1, 2'd3, 64'h0);
      send_op(1, TYPE_DOUBLE, 64'h0000000000000000);
      send_op(1, TYPE_DOUBLE, 64'h8000000000000000);     // -0 reuses +0
      send_op(1, TYPE_DOUBLE, 64'h7FF8000000000001);     // NaN never matches
      send_op(1, TYPE_DOUBLE, 64'h7FF8000000000001);
      send_op(1, TYPE_DOUBLE, 64'hFFF0000000000000);
      send_op(1, TYPE_SINGLE, 64'h8000000000000000);
      send_op(1, TYPE_SINGLE, 64'h0000000000000001);     // tiny -> zero, reuse
      send_op(1, TYPE_SINGLE, 64'h47F0000000000000);     // overflow to inf
      send_op(1, TYPE_SINGLE, 64'h7FF0000000000000);     // inf reuse
      send_op(1, TYPE_SINGLE, 64'hFFFFFFFFFFFFFFFF);     // NaN keeps payload
      send_op(1, TYPE_SINGLE, 64'h36A0000000000000);     // smallest subnormal
      send_op(1, TYPE_SINGLE, 64'h3690000000000000);     // half tie -> zero
      send_op(1, TYPE_SINGLE, 64'h3FF0000010000000);     // tie to even
      send_op(1, TYPE_SINGLE, 64'h3FF0000030000000);     // tie rounds up
      send_op(1, TYPE_SINGLE, 64'h47EFFFFFF0000000);     // rounds to inf
      send_op(1, TYPE_SINGLE, 64'h3FF0000000000000);
      send_op(1, TYPE_SINGLE, 64'h3FF0000000000001);     // narrows to 1.0
      // random: mostly constants of float type, some noise
      for (int n = 0; n < 1530; n++) begin
         t = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                         : 2'($urandom_range(0, 1));
         send_op($urandom_range(0, 15) != 0, t, pick_value());
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

[filelist.f]
rtl/fcdp_pkg.sv
rtl/fcdp_ctrl.sv
rtl/fcdp_dpath.sv
rtl/float_constant_dedup_pool.sv
verif/tb_float_constant_dedup_pool.sv
